/* src/allele_read_stats_accumulator_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the allele read statistics accumulator
// Shared property forms; each expects clk and rst_n in the enclosing scope.
// ---------------------------------------------------------------------------
`ifndef ALLELE_READ_STATS_ACCUMULATOR_MACROS_SVH
`define ALLELE_READ_STATS_ACCUMULATOR_MACROS_SVH

// same-cycle implication
`define ARSA_ASSERT_SAME(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("arsa assertion failed");

// next-cycle implication
`define ARSA_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("arsa assertion failed");

`endif

/* src/arsa_pkg.sv */
// ---------------------------------------------------------------------------
// arsa_pkg
// Types and fixed constants of the allele read statistics accumulator.
// ---------------------------------------------------------------------------
package arsa_pkg;

    localparam int KEY_W          = 32;
    localparam int COUNT_W        = 16;
    localparam int DIV_NUM_W      = 32;
    localparam int DIV_Q_W        = 16;
    localparam int DIV_RADIX_BITS = 2;

    localparam logic [7:0]         LIMIT_RESET = 8'd20;
    localparam logic [COUNT_W-1:0] COUNT_MAX   = '1;

    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [COUNT_W-1:0] count;
    } entry_t;

endpackage

/* src/arsa_ram.sv */
// ---------------------------------------------------------------------------
// arsa_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ---------------------------------------------------------------------------
module arsa_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 64,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* src/arsa_div.sv */
// ---------------------------------------------------------------------------
// arsa_div
// Serial restoring divider, two quotient bits per cycle, 16-bit saturated
// quotient; a zero divisor gives zero.
// ---------------------------------------------------------------------------
module arsa_div
    import arsa_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [DIV_NUM_W-1:0] num,
    input  logic [DIV_Q_W-1:0]   den,
    output logic                 done,
    output logic [DIV_Q_W-1:0]   quo
);

    localparam int STEPS = DIV_Q_W / DIV_RADIX_BITS;
    localparam int CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [DIV_Q_W-1:0] rem_reg, rem_next;
    logic [DIV_Q_W-1:0] quo_reg, quo_next;
    logic [DIV_Q_W-1:0] den_reg, den_next;

    logic [DIV_Q_W-1:0] rem_step;
    logic [DIV_Q_W-1:0] quo_step;
    logic [DIV_Q_W:0]   trial;

    always_comb
    begin
        rem_step = rem_reg;
        quo_step = quo_reg;
        trial    = '0;
        for (int i = 0; i < DIV_RADIX_BITS; i++)
        begin
            trial = {rem_step, quo_step[DIV_Q_W-1]};
            if (trial >= {1'b0, den_reg})
            begin
                rem_step = DIV_Q_W'(trial - {1'b0, den_reg});
                quo_step = {quo_step[DIV_Q_W-2:0], 1'b1};
            end
            else
            begin
                rem_step = trial[DIV_Q_W-1:0];
                quo_step = {quo_step[DIV_Q_W-2:0], 1'b0};
            end
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        if (start)
        begin
            if (den == '0)
            begin
                quo_next  = '0;
                done_next = 1'b1;
            end
            else if (num[DIV_NUM_W-1 -: DIV_Q_W] >= den)
            begin
                quo_next  = '1;
                done_next = 1'b1;
            end
            else
            begin
                rem_next  = num[DIV_NUM_W-1 -: DIV_Q_W];
                quo_next  = num[DIV_Q_W-1:0];
                den_next  = den;
                cnt_next  = CNT_W'(STEPS - 1);
                busy_next = 1'b1;
            end
        end
        else if (busy_reg)
        begin
            rem_next = rem_step;
            quo_next = quo_step;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

/* src/allele_read_stats_accumulator.sv */
// ---------------------------------------------------------------------------
// allele_read_stats_accumulator
// Read statistics for one candidate allele: counters, sums, a bounded
// start-key count table in RAM, and serially divided means and rate.
// ---------------------------------------------------------------------------
//  channel   handshake                  payload
//  -------   -------------------------  ---------------------------------
//  item      start & !busy              operation .. start_key
//  result    done (one-cycle strobe)    reads_seen .. table_overflow
//  config    cfg_valid & cfg_ready      cfg_data (low_quality_limit)
//
//  An item runs through the table scan and then the four divisions before its
//  done strobe: the table scan reads the filled entries, one RAM entry a cycle,
//  and stops at a hit; the four quotients share one divider in turn, and a zero
//  divisor or a saturated quotient finishes its division without serial steps.
//  busy is low again in the done cycle; the next item may transfer there.
//  Reset clears the counters and the table fill count; no clearing pass.
//  The receiver cannot stall; cfg_ready is always high.
// ---------------------------------------------------------------------------
module allele_read_stats_accumulator
    import arsa_pkg::*;
#(
    parameter int TABLE_ENTRIES = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        operation,
    input  logic [7:0]  base_quality,
    input  logic        forward_strand,
    input  logic [15:0] relative_position,
    input  logic [15:0] neighbour_quality,
    input  logic [31:0] start_key,
    output logic        done,
    output logic [15:0] reads_seen,
    output logic [15:0] forward_reads,
    output logic [15:0] mean_quality,
    output logic [15:0] mean_position,
    output logic [15:0] mean_neighbour_quality,
    output logic [15:0] low_quality_rate,
    output logic [15:0] total_start_count,
    output logic [15:0] key_count,
    output logic        table_overflow,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data
);

    localparam int ADDR_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W  = $clog2(TABLE_ENTRIES + 1);

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_SEARCH   = 3'd1;
    localparam logic [2:0] ST_UPDATE   = 3'd2;
    localparam logic [2:0] ST_DIV_GO   = 3'd3;
    localparam logic [2:0] ST_DIV_WAIT = 3'd4;

    localparam logic [1:0] SEL_QUALITY  = 2'd0;
    localparam logic [1:0] SEL_POSITION = 2'd1;
    localparam logic [1:0] SEL_NEIGHBOR = 2'd2;
    localparam logic [1:0] SEL_RATE     = 2'd3;

    logic [2:0]         state_reg, state_next;
    logic [7:0]         limit_reg, limit_next;
    logic [15:0]        read_total_reg, read_total_next;
    logic [15:0]        low_total_reg, low_total_next;
    logic [15:0]        fwd_total_reg, fwd_total_next;
    logic [23:0]        quality_sum_reg, quality_sum_next;
    logic [31:0]        position_sum_reg, position_sum_next;
    logic [31:0]        neighbour_sum_reg, neighbour_sum_next;
    logic [CNT_W-1:0]   used_reg, used_next;
    logic [15:0]        start_sum_reg, start_sum_next;
    logic               done_reg, done_next;
    logic [CNT_W-1:0]   scan_idx_reg, scan_idx_next;
    logic               pend_reg, pend_next;
    logic               hit_reg, hit_next;
    logic [1:0]         div_sel_reg, div_sel_next;

    logic               op_reg, op_next;
    logic [7:0]         qual_reg, qual_next;
    logic               fwd_reg, fwd_next;
    logic [15:0]        rpos_reg, rpos_next;
    logic [15:0]        nq_reg, nq_next;
    logic [KEY_W-1:0]   key_reg, key_next;
    logic [ADDR_W-1:0]  pend_idx_reg, pend_idx_next;
    logic [ADDR_W-1:0]  hit_idx_reg, hit_idx_next;
    logic [COUNT_W-1:0] hit_count_reg, hit_count_next;
    logic [15:0]        mean_q_reg, mean_q_next;
    logic [15:0]        mean_p_reg, mean_p_next;
    logic [15:0]        mean_n_reg, mean_n_next;
    logic [15:0]        rate_reg, rate_next;
    logic [15:0]        key_count_reg, key_count_next;
    logic               overflow_reg, overflow_next;

    logic               ram_wr_en;
    logic [ADDR_W-1:0]  ram_wr_addr;
    entry_t             ram_wr_data;
    logic               ram_rd_en;
    logic [ADDR_W-1:0]  ram_rd_addr;
    entry_t             ram_rd_data;

    logic                 div_start;
    logic [DIV_NUM_W-1:0] div_num;
    logic                 div_done;
    logic [DIV_Q_W-1:0]   div_quo;

    logic [24:0] quality_add;
    logic [32:0] position_add;
    logic [32:0] neighbour_add;
    logic        key_match;

    function automatic logic [15:0] sat_inc16(input logic [15:0] v);
        sat_inc16 = (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    arsa_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    arsa_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (read_total_reg),
        .done  (div_done),
        .quo   (div_quo)
    );

    assign ram_rd_addr   = scan_idx_reg[ADDR_W-1:0];
    assign key_match     = pend_reg && (ram_rd_data.key == key_reg);
    assign quality_add   = {1'b0, quality_sum_reg} + 25'(qual_reg);
    assign position_add  = {1'b0, position_sum_reg} + 33'(rpos_reg);
    assign neighbour_add = {1'b0, neighbour_sum_reg} + 33'(nq_reg);

    always_comb
    begin
        unique case (div_sel_reg)
            SEL_QUALITY:  div_num = {quality_sum_reg, 8'd0};
            SEL_POSITION: div_num = position_sum_reg;
            SEL_NEIGHBOR: div_num = neighbour_sum_reg;
            SEL_RATE:     div_num = {low_total_reg, 16'd0};
            default:      div_num = '0;
        endcase
    end

    always_comb
    begin
        state_next         = state_reg;
        limit_next         = limit_reg;
        read_total_next    = read_total_reg;
        low_total_next     = low_total_reg;
        fwd_total_next     = fwd_total_reg;
        quality_sum_next   = quality_sum_reg;
        position_sum_next  = position_sum_reg;
        neighbour_sum_next = neighbour_sum_reg;
        used_next          = used_reg;
        start_sum_next     = start_sum_reg;
        done_next          = 1'b0;
        scan_idx_next      = scan_idx_reg;
        pend_next          = pend_reg;
        hit_next           = hit_reg;
        div_sel_next       = div_sel_reg;
        op_next            = op_reg;
        qual_next          = qual_reg;
        fwd_next           = fwd_reg;
        rpos_next          = rpos_reg;
        nq_next            = nq_reg;
        key_next           = key_reg;
        pend_idx_next      = pend_idx_reg;
        hit_idx_next       = hit_idx_reg;
        hit_count_next     = hit_count_reg;
        mean_q_next        = mean_q_reg;
        mean_p_next        = mean_p_reg;
        mean_n_next        = mean_n_reg;
        rate_next          = rate_reg;
        key_count_next     = key_count_reg;
        overflow_next      = overflow_reg;
        ram_wr_en          = 1'b0;
        ram_wr_addr        = hit_idx_reg;
        ram_wr_data        = '{key: key_reg, count: hit_count_reg};
        ram_rd_en          = 1'b0;
        div_start          = 1'b0;

        if (cfg_valid)
        begin
            limit_next = cfg_data;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    op_next       = operation;
                    qual_next     = base_quality;
                    fwd_next      = forward_strand;
                    rpos_next     = relative_position;
                    nq_next       = neighbour_quality;
                    key_next      = start_key;
                    scan_idx_next = '0;
                    pend_next     = 1'b0;
                    hit_next      = 1'b0;
                    state_next    = ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                if (key_match)
                begin
                    hit_next       = 1'b1;
                    hit_idx_next   = pend_idx_reg;
                    hit_count_next = ram_rd_data.count;
                    pend_next      = 1'b0;
                    state_next     = ST_UPDATE;
                end
                else if (scan_idx_reg < used_reg)
                begin
                    ram_rd_en     = 1'b1;
                    pend_next     = 1'b1;
                    pend_idx_next = scan_idx_reg[ADDR_W-1:0];
                    scan_idx_next = scan_idx_reg + 1'b1;
                end
                else
                begin
                    pend_next  = 1'b0;
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                overflow_next  = 1'b0;
                key_count_next = hit_reg ? hit_count_reg : 16'd0;
                if (op_reg == OP_ADD)
                begin
                    read_total_next = sat_inc16(read_total_reg);
                    if (qual_reg < limit_reg)
                    begin
                        low_total_next = sat_inc16(low_total_reg);
                    end
                    if (fwd_reg)
                    begin
                        fwd_total_next = sat_inc16(fwd_total_reg);
                    end
                    quality_sum_next   = quality_add[24] ? '1 : quality_add[23:0];
                    position_sum_next  = position_add[32] ? '1 : position_add[31:0];
                    neighbour_sum_next = neighbour_add[32] ? '1 : neighbour_add[31:0];
                    if (hit_reg)
                    begin
                        if (hit_count_reg != COUNT_MAX)
                        begin
                            ram_wr_en         = 1'b1;
                            ram_wr_data.count = hit_count_reg + 1'b1;
                            key_count_next    = hit_count_reg + 1'b1;
                            start_sum_next    = sat_inc16(start_sum_reg);
                        end
                    end
                    else if (used_reg < CNT_W'(TABLE_ENTRIES))
                    begin
                        ram_wr_en         = 1'b1;
                        ram_wr_addr       = used_reg[ADDR_W-1:0];
                        ram_wr_data.count = COUNT_W'(1);
                        key_count_next    = 16'd1;
                        used_next         = used_reg + 1'b1;
                        start_sum_next    = sat_inc16(start_sum_reg);
                    end
                    else
                    begin
                        overflow_next = 1'b1;
                    end
                end
                div_sel_next = SEL_QUALITY;
                state_next   = ST_DIV_GO;
            end
            ST_DIV_GO:
            begin
                div_start  = 1'b1;
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (div_done)
                begin
                    unique case (div_sel_reg)
                        SEL_QUALITY:  mean_q_next = div_quo;
                        SEL_POSITION: mean_p_next = div_quo;
                        SEL_NEIGHBOR: mean_n_next = div_quo;
                        SEL_RATE:     rate_next   = div_quo;
                        default:      rate_next   = div_quo;
                    endcase
                    if (div_sel_reg == SEL_RATE)
                    begin
                        done_next  = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        div_sel_next = div_sel_reg + 1'b1;
                        state_next   = ST_DIV_GO;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            limit_reg         <= LIMIT_RESET;
            read_total_reg    <= '0;
            low_total_reg     <= '0;
            fwd_total_reg     <= '0;
            quality_sum_reg   <= '0;
            position_sum_reg  <= '0;
            neighbour_sum_reg <= '0;
            used_reg          <= '0;
            start_sum_reg     <= '0;
            done_reg          <= 1'b0;
            scan_idx_reg      <= '0;
            pend_reg          <= 1'b0;
            hit_reg           <= 1'b0;
            div_sel_reg       <= SEL_QUALITY;
        end
        else
        begin
            state_reg         <= state_next;
            limit_reg         <= limit_next;
            read_total_reg    <= read_total_next;
            low_total_reg     <= low_total_next;
            fwd_total_reg     <= fwd_total_next;
            quality_sum_reg   <= quality_sum_next;
            position_sum_reg  <= position_sum_next;
            neighbour_sum_reg <= neighbour_sum_next;
            used_reg          <= used_next;
            start_sum_reg     <= start_sum_next;
            done_reg          <= done_next;
            scan_idx_reg      <= scan_idx_next;
            pend_reg          <= pend_next;
            hit_reg           <= hit_next;
            div_sel_reg       <= div_sel_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        qual_reg      <= qual_next;
        fwd_reg       <= fwd_next;
        rpos_reg      <= rpos_next;
        nq_reg        <= nq_next;
        key_reg       <= key_next;
        pend_idx_reg  <= pend_idx_next;
        hit_idx_reg   <= hit_idx_next;
        hit_count_reg <= hit_count_next;
        mean_q_reg    <= mean_q_next;
        mean_p_reg    <= mean_p_next;
        mean_n_reg    <= mean_n_next;
        rate_reg      <= rate_next;
        key_count_reg <= key_count_next;
        overflow_reg  <= overflow_next;
    end

    assign busy                   = (state_reg != ST_IDLE);
    assign cfg_ready              = 1'b1;
    assign done                   = done_reg;
    assign reads_seen             = read_total_reg;
    assign forward_reads          = fwd_total_reg;
    assign mean_quality           = mean_q_reg;
    assign mean_position          = mean_p_reg;
    assign mean_neighbour_quality = mean_n_reg;
    assign low_quality_rate       = rate_reg;
    assign total_start_count      = start_sum_reg;
    assign key_count              = key_count_reg;
    assign table_overflow         = overflow_reg;

endmodule

/* src/arsa_checker.sv */
// ---------------------------------------------------------------------------
// arsa_checker
// Port-level checks of the allele read statistics accumulator.
// ---------------------------------------------------------------------------
`include "allele_read_stats_accumulator_macros.svh"

module arsa_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input logic [15:0] reads_seen,
    input logic [15:0] forward_reads,
    input logic [15:0] mean_quality,
    input logic [15:0] mean_position,
    input logic [15:0] mean_neighbour_quality,
    input logic [15:0] low_quality_rate
);

    `ARSA_ASSERT_NEXT(a_transfer_busy, start && !busy, busy)
    `ARSA_ASSERT_SAME(a_done_idle, done, !busy)
    `ARSA_ASSERT_NEXT(a_done_pulse, done, !done)
    `ARSA_ASSERT_SAME(a_forward_bound, done, forward_reads <= reads_seen)
    `ARSA_ASSERT_SAME(a_empty_means, done && (reads_seen == 16'd0), (mean_quality == 16'd0) && (mean_position == 16'd0) && (mean_neighbour_quality == 16'd0) && (low_quality_rate == 16'd0))

endmodule

bind allele_read_stats_accumulator arsa_checker u_arsa_checker (.*);

/* dv/tb_allele_read_stats_accumulator.sv */
// ---------------------------------------------------------------------------
// tb_allele_read_stats_accumulator
// Self-checking bench for the allele read statistics accumulator. A short
// directed run covers empty statistics, rate of one, limit edges, key reuse
// and field extremes. Random add/query traffic over a reused key pool then
// fills the start table until new keys are dropped. It runs under several
// low-quality limits, including 0 and 255, with random sender gaps. Every
// done strobe is checked field by field against an in-bench statistics model.
// ---------------------------------------------------------------------------
module tb_allele_read_stats_accumulator
    import arsa_pkg::*;
();

    localparam int TABLE_DEPTH = 64;
    localparam int CYCLE_LIMIT = 600000;
    localparam int PHASE_ITEMS = 100;

    typedef struct packed {
        logic        op;
        logic [7:0]  quality;
        logic        fwd;
        logic [15:0] position;
        logic [15:0] neighbour;
        logic [31:0] key;
    } read_obs_t;

    typedef struct packed {
        logic [15:0] reads;
        logic [15:0] forward;
        logic [15:0] mean_qual;
        logic [15:0] mean_pos;
        logic [15:0] mean_nb;
        logic [15:0] low_rate;
        logic [15:0] start_total;
        logic [15:0] key_hits;
        logic        overflow;
    } allele_stats_t;

    class allele_stats_tracker;
        bit [7:0]          limit;
        longint unsigned   read_total, low_total, fwd_total;
        longint unsigned   qual_sum, pos_sum, nb_sum, start_sum;
        bit [31:0]         keys[$];
        longint unsigned   counts[$];
        allele_stats_t     expected_stats[$];
        int unsigned       mismatches, unexpected, checked, overflows;

        function new();
            limit = LIMIT_RESET;
        endfunction

        function longint unsigned sat_add(longint unsigned a, longint unsigned b,
                                          longint unsigned top);
            return (a + b > top) ? top : a + b;
        endfunction

        function bit [15:0] ratio(longint unsigned num, longint unsigned den);
            longint unsigned q;
            if (den == 0)
                return 16'd0;
            q = num / den;
            return (q > 64'hFFFF) ? 16'hFFFF : q[15:0];
        endfunction

        function int find_key(bit [31:0] key);
            foreach (keys[i])
                if (keys[i] == key)
                    return i;
            return -1;
        endfunction

        function void note_read(read_obs_t r);
            allele_stats_t s;
            int slot;
            s.overflow = 1'b0;
            if (r.op == OP_ADD)
            begin
                read_total = sat_add(read_total, 1, 64'hFFFF);
                if (r.quality < limit)
                    low_total = sat_add(low_total, 1, 64'hFFFF);
                if (r.fwd)
                    fwd_total = sat_add(fwd_total, 1, 64'hFFFF);
                qual_sum = sat_add(qual_sum, r.quality, 64'hFF_FFFF);
                pos_sum  = sat_add(pos_sum, r.position, 64'hFFFF_FFFF);
                nb_sum   = sat_add(nb_sum, r.neighbour, 64'hFFFF_FFFF);
                slot = find_key(r.key);
                if (slot >= 0)
                begin
                    if (counts[slot] < COUNT_MAX)
                    begin
                        counts[slot]++;
                        start_sum = sat_add(start_sum, 1, 64'hFFFF);
                    end
                end
                else if (keys.size() < TABLE_DEPTH)
                begin
                    keys.insert(keys.size(), r.key);
                    counts.insert(counts.size(), 1);
                    start_sum = sat_add(start_sum, 1, 64'hFFFF);
                end
                else
                begin
                    s.overflow = 1'b1;
                    overflows++;
                end
            end
            slot = find_key(r.key);
            s.reads       = read_total[15:0];
            s.forward     = fwd_total[15:0];
            s.mean_qual   = ratio(qual_sum << 8, read_total);
            s.mean_pos    = ratio(pos_sum, read_total);
            s.mean_nb     = ratio(nb_sum, read_total);
            s.low_rate    = ratio(low_total << 16, read_total);
            s.start_total = start_sum[15:0];
            s.key_hits    = (slot >= 0) ? counts[slot][15:0] : 16'd0;
            expected_stats.insert(expected_stats.size(), s);
        endfunction

        function void compare_field(string name, logic [15:0] want, logic [15:0] got);
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch on result %0d: %s expected %h, got %h",
                             checked, name, want, got);
            end
        endfunction

        function void check_stats(allele_stats_t got);
            allele_stats_t want;
            if (expected_stats.size() == 0)
            begin
                unexpected++;
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: result with nothing expected, reads_seen %h",
                             got.reads);
                return;
            end
            want = expected_stats.pop_front();
            checked++;
            compare_field("reads_seen", want.reads, got.reads);
            compare_field("forward_reads", want.forward, got.forward);
            compare_field("mean_quality", want.mean_qual, got.mean_qual);
            compare_field("mean_position", want.mean_pos, got.mean_pos);
            compare_field("mean_neighbour_quality", want.mean_nb, got.mean_nb);
            compare_field("low_quality_rate", want.low_rate, got.low_rate);
            compare_field("total_start_count", want.start_total, got.start_total);
            compare_field("key_count", want.key_hits, got.key_hits);
            compare_field("table_overflow", {15'd0, want.overflow}, {15'd0, got.overflow});
        endfunction
    endclass

    logic        clk;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        operation = OP_ADD;
    logic [7:0]  base_quality = '0;
    logic        forward_strand = 1'b0;
    logic [15:0] relative_position = '0;
    logic [15:0] neighbour_quality = '0;
    logic [31:0] start_key = '0;
    logic        done;
    logic [15:0] reads_seen;
    logic [15:0] forward_reads;
    logic [15:0] mean_quality;
    logic [15:0] mean_position;
    logic [15:0] mean_neighbour_quality;
    logic [15:0] low_quality_rate;
    logic [15:0] total_start_count;
    logic [15:0] key_count;
    logic        table_overflow;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_data = '0;

    allele_stats_tracker tracker;
    bit [31:0]   known_keys[$];
    bit          key_seen[bit [31:0]];
    int unsigned add_count, query_count, limit_writes;
    int unsigned cycle_count = 0;

    allele_read_stats_accumulator #(
        .TABLE_ENTRIES(TABLE_DEPTH)
    ) dut (
        .clk                    (clk),
        .rst_n                  (rst_n),
        .start                  (start),
        .busy                   (busy),
        .operation              (operation),
        .base_quality           (base_quality),
        .forward_strand         (forward_strand),
        .relative_position      (relative_position),
        .neighbour_quality      (neighbour_quality),
        .start_key              (start_key),
        .done                   (done),
        .reads_seen             (reads_seen),
        .forward_reads          (forward_reads),
        .mean_quality           (mean_quality),
        .mean_position          (mean_position),
        .mean_neighbour_quality (mean_neighbour_quality),
        .low_quality_rate       (low_quality_rate),
        .total_start_count      (total_start_count),
        .key_count              (key_count),
        .table_overflow         (table_overflow),
        .cfg_valid              (cfg_valid),
        .cfg_ready              (cfg_ready),
        .cfg_data               (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
            tracker.check_stats(allele_stats_t'({reads_seen, forward_reads, mean_quality,
                mean_position, mean_neighbour_quality, low_quality_rate,
                total_start_count, key_count, table_overflow}));
    end

    function automatic read_obs_t make_read(logic op, logic [7:0] q, logic f,
                                            logic [15:0] p, logic [15:0] n,
                                            logic [31:0] k);
        read_obs_t r;
        r = {op, q, f, p, n, k};
        return r;
    endfunction

    function automatic read_obs_t random_read();
        read_obs_t r;
        int pick;
        r.op  = ($urandom_range(99) < 18) ? OP_QUERY : OP_ADD;
        r.fwd = 1'($urandom_range(1));
        case ($urandom_range(9))
            6:       r.quality = tracker.limit - 8'd1;
            7:       r.quality = tracker.limit;
            8:       r.quality = 8'd0;
            9:       r.quality = 8'hFF;
            default: r.quality = 8'($urandom_range(255));
        endcase
        r.position  = ($urandom_range(9) == 0) ? 16'hFFFF : 16'($urandom);
        r.neighbour = ($urandom_range(9) == 0) ? 16'h0000 : 16'($urandom);
        pick = $urandom_range(99);
        if (known_keys.size() > 0 && pick < 70)
            r.key = known_keys[$urandom_range(known_keys.size() - 1)];
        else if (pick < 75)
            r.key = pick[0] ? 32'hFFFF_FFFF : 32'h0;
        else
            r.key = $urandom;
        return r;
    endfunction

    task automatic send_read(read_obs_t r);
        start             <= 1'b1;
        operation         <= r.op;
        base_quality      <= r.quality;
        forward_strand    <= r.fwd;
        relative_position <= r.position;
        neighbour_quality <= r.neighbour;
        start_key         <= r.key;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        tracker.note_read(r);
        if (r.op == OP_ADD)
        begin
            add_count++;
            if (!key_seen.exists(r.key))
            begin
                key_seen[r.key] = 1'b1;
                known_keys.insert(known_keys.size(), r.key);
            end
        end
        else
            query_count++;
    endtask

    task automatic hold_off(int cycles);
        start             <= 1'b0;
        operation         <= 1'($urandom_range(1));
        base_quality      <= 8'($urandom_range(255));
        start_key         <= $urandom;
        relative_position <= 16'($urandom);
        repeat (cycles) @(posedge clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (tracker.expected_stats.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_limit(logic [7:0] value);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        cfg_valid <= 1'b0;
        tracker.limit = value;
        limit_writes++;
    endtask

    initial
    begin
        logic [7:0] phase_limits[5];
        read_obs_t  directed[$];

        tracker = new();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed = {directed,
                    make_read(OP_QUERY, 8'd30, 1'b1, 16'h1234, 16'h5678, 32'h0)};
        directed = {directed,
                    make_read(OP_ADD, 8'd0, 1'b0, 16'h0000, 16'h0000, 32'h0)};
        directed = {directed,
                    make_read(OP_ADD, 8'hFF, 1'b1, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF)};
        directed = {directed,
                    make_read(OP_ADD, 8'd19, 1'b0, 16'h8000, 16'h0100, 32'h0)};
        directed = {directed,
                    make_read(OP_ADD, 8'd20, 1'b1, 16'h0001, 16'h8000, 32'h0)};
        directed = {directed,
                    make_read(OP_ADD, 8'd21, 1'b1, 16'h7FFF, 16'h00FF, 32'h8000_0001)};
        directed = {directed,
                    make_read(OP_QUERY, 8'd0, 1'b0, 16'h0, 16'h0, 32'hFFFF_FFFF)};
        directed = {directed,
                    make_read(OP_QUERY, 8'hFF, 1'b1, 16'hFFFF, 16'hFFFF, 32'h1234_5678)};
        directed = {directed,
                    make_read(OP_QUERY, 8'd5, 1'b0, 16'h0, 16'h0, 32'h0)};
        directed = {directed,
                    make_read(OP_ADD, 8'hAA, 1'b0, 16'h5555, 16'hAAAA, 32'h5555_AAAA)};
        directed = {directed,
                    make_read(OP_ADD, 8'h55, 1'b1, 16'hAAAA, 16'h5555, 32'hAAAA_5555)};
        directed = {directed,
                    make_read(OP_ADD, 8'hFF, 1'b1, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF)};
        directed = {directed,
                    make_read(OP_QUERY, 8'h0, 1'b0, 16'h0, 16'h0, 32'h8000_0001)};
        foreach (directed[i])
            send_read(directed[i]);

        write_limit(8'd0);
        send_read(make_read(OP_ADD, 8'd0, 1'b0, 16'h0, 16'h0, 32'h0));
        write_limit(8'hFF);
        send_read(make_read(OP_ADD, 8'hFE, 1'b1, 16'h1, 16'h1, 32'h0));
        send_read(make_read(OP_ADD, 8'hFF, 1'b0, 16'h2, 16'h2, 32'hFFFF_FFFF));

        phase_limits[0] = 8'd0;
        phase_limits[1] = 8'hFF;
        phase_limits[2] = 8'($urandom_range(255));
        phase_limits[3] = 8'd128;
        phase_limits[4] = 8'($urandom_range(255));
        foreach (phase_limits[p])
        begin
            write_limit(phase_limits[p]);
            repeat (PHASE_ITEMS)
            begin
                if (p != 2 && $urandom_range(99) < 30)
                    hold_off($urandom_range(1, 64));
                send_read(random_read());
            end
        end

        drain();
        repeat (150) @(posedge clk);

        $display("summary: %0d adds, %0d queries, %0d results checked, %0d limit writes",
                 add_count, query_count, tracker.checked, limit_writes);
        $display("summary: %0d start keys stored, %0d dropped on a full table, %0d mismatches",
                 tracker.keys.size(), tracker.overflows, tracker.mismatches);
        if (tracker.mismatches == 0 && tracker.unexpected == 0 &&
            tracker.expected_stats.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
